/* hw/rtl/grid_astar_router_defines.svh */
// Assertion macros for the RTL file that checks its own logic.
`ifndef GRID_ASTAR_ROUTER_DEFINES_SVH
`define GRID_ASTAR_ROUTER_DEFINES_SVH
`ifndef SYNTHESIS
`define GAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid router check failed");
`define GAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid router check failed");
`else
`define GAR_ASSERT_IMP(lbl, ante, cons)
`define GAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/gar_pkg.sv */
`timescale 1ns / 1ps
package gar_pkg;

    localparam int X_W    = 6;
    localparam int Y_W    = 5;
    localparam int CELL_W = X_W + Y_W;
    localparam int NCELLS = 1 << CELL_W;
    localparam int GRID_W = 1 << X_W;
    localparam int GRID_H = 1 << Y_W;
    localparam int FRAC   = 8;
    localparam int G_W    = CELL_W;
    localparam int CNT_W  = CELL_W + 1;
    localparam int S_W    = 2 * X_W + 1;
    localparam int RAD_W  = ((S_W + 2 * FRAC + 1) / 2) * 2;
    localparam int H_W    = RAD_W / 2;
    localparam int F_W    = G_W + FRAC + 1;
    localparam int SC_W   = $clog2(H_W + 1);

    localparam logic [1:0] FLAG_NONE   = 2'b00;
    localparam logic [1:0] FLAG_OPEN   = 2'b01;
    localparam logic [1:0] FLAG_CLOSED = 2'b10;
    localparam int OPEN_BIT   = 0;
    localparam int CLOSED_BIT = 1;

    typedef enum logic [1:0] {
        OP_OBST   = 2'd0,
        OP_ROUTE  = 2'd1,
        OP_READ   = 2'd2,
        OP_UNRESV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_XM = 2'd0,
        DIR_YM = 2'd1,
        DIR_YP = 2'd2,
        DIR_XP = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHK_S, S_CHK_E, S_FCLR, S_HS, S_HSW, S_SCAN,
        S_DEL, S_NB, S_NCHK, S_NH, S_BT, S_BT2, S_RDP, S_RCLR
    } state_t;

    typedef struct packed {
        logic [G_W-1:0] g;
        logic [H_W-1:0] h;
        dir_t           d;
    } node_t;

    typedef struct packed {
        logic           go;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] ex;
        logic [Y_W-1:0] ey;
    } heur_req_t;

    typedef struct packed {
        logic           done;
        logic [H_W-1:0] h;
    } heur_rsp_t;

endpackage

/* hw/rtl/gar_heur.sv */
`timescale 1ns / 1ps
module gar_heur
    import gar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  heur_req_t req,
    output heur_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SC_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [H_W+1:0]   rem_reg, rem_next;
    logic [H_W-1:0]   root_reg, root_next;

    logic [X_W-1:0]   dx;
    logic [Y_W-1:0]   dy;
    logic [2*X_W-1:0] dx2;
    logic [2*Y_W-1:0] dy2;
    logic [S_W-1:0]   sum;
    logic [H_W+1:0]   rem_sh;
    logic [H_W+1:0]   trial;

    assign dx     = (req.x > req.ex) ? req.x - req.ex : req.ex - req.x;
    assign dy     = (req.y > req.ey) ? req.y - req.ey : req.ey - req.y;
    assign dx2    = dx * dx;
    assign dy2    = dy * dy;
    assign sum    = S_W'(dx2) + S_W'(dy2);
    assign rem_sh = {rem_reg[H_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // One root bit is settled per cycle, two radicand bits consumed.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = SC_W'(H_W);
            rad_next  = RAD_W'(sum) << (2 * FRAC);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[H_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[H_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - SC_W'(1);
            if (cnt_reg == SC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.h    = root_reg;

endmodule

/* hw/rtl/grid_astar_router.sv */
`timescale 1ns / 1ps
// Grid router over a 64 x 32 cell map with 4-connected A* search. A command word
// is taken when start is high and busy is low; each command returns exactly one
// result word, shown for a single cycle with done high, and the receiver cannot
// stall it, so it must capture found, path_length, step_valid, step_x and step_y
// in that cycle. After reset the block is busy while the obstacle and
// reservation maps are cleared. An obstacle write answers in the cycle after it
// is taken, a path step read after its registered path memory read, and a
// reservation clear once the whole reservation map is swept. A route first checks
// the start and end cells for obstacles, then clears the open and closed marks,
// then for each expanded cell scans the whole open list, closes the gap in the
// list by moving each entry behind the chosen one forward and tries four
// neighbors, each update waiting on the shared square root unit; a found path is
// then written back and reserved cell by cell from the goal.
`include "grid_astar_router_defines.svh"
module grid_astar_router
    import gar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [X_W-1:0]    start_x,
    input  logic [Y_W-1:0]    start_y,
    input  logic [X_W-1:0]    end_x,
    input  logic [Y_W-1:0]    end_y,
    input  logic              blocked,
    input  logic [CELL_W-1:0] step_index,
    output logic              done,
    output logic              found,
    output logic [G_W-1:0]    path_length,
    output logic              step_valid,
    output logic [X_W-1:0]    step_x,
    output logic [Y_W-1:0]    step_y
);

    logic        obst_mem [NCELLS];
    logic        resv_mem [NCELLS];
    logic [1:0]  flag_mem [NCELLS];
    node_t       node_mem [NCELLS];
    logic [CELL_W-1:0] ord_mem  [NCELLS];
    logic [CELL_W-1:0] path_mem [NCELLS];

    logic              obst_we, obst_wd, obst_rd_reg;
    logic [CELL_W-1:0] obst_wa, obst_ra;
    logic              resv_we, resv_wd, resv_rd_reg;
    logic [CELL_W-1:0] resv_wa, resv_ra;
    logic              flag_we;
    logic [1:0]        flag_wd, flag_rd_reg;
    logic [CELL_W-1:0] flag_wa, flag_ra;
    logic              node_we;
    node_t             node_wd, node_rd_reg;
    logic [CELL_W-1:0] node_wa, node_ra;
    logic              ord_we;
    logic [CELL_W-1:0] ord_wa, ord_ra, ord_wd, ord_rd_reg;
    logic              path_we;
    logic [CELL_W-1:0] path_wa, path_ra, path_wd, path_rd_reg;

    state_t            state_reg, state_next;
    logic [CELL_W-1:0] sweep_reg, sweep_next;
    logic [G_W-1:0]    stored_len_reg, stored_len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              p1_v_reg, p1_v_next;
    logic              p2_v_reg, p2_v_next;
    logic              best_v_reg, best_v_next;
    logic [CNT_W-1:0]  del_j_reg, del_j_next;
    logic              del_v_reg, del_v_next;
    dir_t              dir_reg, dir_next;
    logic [G_W-1:0]    bt_pos_reg, bt_pos_next;
    logic              nopen_reg, nopen_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic              step_valid_reg, step_valid_next;

    logic [X_W-1:0]    sx_reg, sx_next, ex_reg, ex_next, step_x_reg, step_x_next;
    logic [Y_W-1:0]    sy_reg, sy_next, ey_reg, ey_next, step_y_reg, step_y_next;
    logic [CELL_W-1:0] idx_reg, idx_next;
    logic [CELL_W-1:0] p1_idx_reg, p1_idx_next, p2_idx_reg, p2_idx_next;
    logic [CELL_W-1:0] p2_cell_reg, p2_cell_next;
    logic [F_W-1:0]    best_f_reg, best_f_next;
    logic [CELL_W-1:0] best_idx_reg, best_idx_next, best_cell_reg, best_cell_next;
    logic [G_W-1:0]    best_g_reg, best_g_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [G_W-1:0]    cur_g_reg, cur_g_next;
    logic [CELL_W-1:0] del_a_reg, del_a_next;
    logic [CELL_W-1:0] n_reg, n_next;

    heur_req_t         hreq;
    heur_rsp_t         hrsp;

    logic [X_W-1:0]    cur_x;
    logic [Y_W-1:0]    cur_y;
    logic              nb_ok, pa_ok;
    logic [CELL_W-1:0] nb_cell, pa_cell;
    logic [G_W-1:0]    ng;
    logic [F_W-1:0]    scan_f;
    logic              fin, adv_dir;

    gar_heur u_heur (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    always_ff @(posedge clk)
    begin
        if (obst_we)
            obst_mem[obst_wa] <= obst_wd;
        obst_rd_reg <= obst_mem[obst_ra];
    end

    always_ff @(posedge clk)
    begin
        if (resv_we)
            resv_mem[resv_wa] <= resv_wd;
        resv_rd_reg <= resv_mem[resv_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_wa] <= flag_wd;
        flag_rd_reg <= flag_mem[flag_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        node_rd_reg <= node_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        ord_rd_reg <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_wa] <= path_wd;
        path_rd_reg <= path_mem[path_ra];
    end

    assign cur_x  = cur_reg[X_W-1:0];
    assign cur_y  = cur_reg[CELL_W-1:X_W];
    assign ng     = cur_g_reg + G_W'(1);
    assign scan_f = (F_W'(node_rd_reg.g) << FRAC) + F_W'(node_rd_reg.h);

    always_comb
    begin
        nb_ok   = 1'b0;
        nb_cell = cur_reg;
        unique case (dir_reg)
            DIR_XM:
            begin
                nb_ok   = cur_x != '0;
                nb_cell = {cur_y, cur_x - X_W'(1)};
            end
            DIR_YM:
            begin
                nb_ok   = cur_y != '0;
                nb_cell = {cur_y - Y_W'(1), cur_x};
            end
            DIR_YP:
            begin
                nb_ok   = cur_y != Y_W'(GRID_H - 1);
                nb_cell = {cur_y + Y_W'(1), cur_x};
            end
            DIR_XP:
            begin
                nb_ok   = cur_x != X_W'(GRID_W - 1);
                nb_cell = {cur_y, cur_x + X_W'(1)};
            end
        endcase
    end

    // The parent lies opposite to the direction the cell was entered by.
    always_comb
    begin
        pa_ok   = 1'b0;
        pa_cell = cur_reg;
        unique case (node_rd_reg.d)
            DIR_XM:
            begin
                pa_ok   = cur_x != X_W'(GRID_W - 1);
                pa_cell = {cur_y, cur_x + X_W'(1)};
            end
            DIR_YM:
            begin
                pa_ok   = cur_y != Y_W'(GRID_H - 1);
                pa_cell = {cur_y + Y_W'(1), cur_x};
            end
            DIR_YP:
            begin
                pa_ok   = cur_y != '0;
                pa_cell = {cur_y - Y_W'(1), cur_x};
            end
            DIR_XP:
            begin
                pa_ok   = cur_x != '0;
                pa_cell = {cur_y, cur_x - X_W'(1)};
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        stored_len_next = stored_len_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        p1_v_next       = 1'b0;
        p2_v_next       = 1'b0;
        best_v_next     = best_v_reg;
        del_j_next      = del_j_reg;
        del_v_next      = 1'b0;
        dir_next        = dir_reg;
        bt_pos_next     = bt_pos_reg;
        nopen_next      = nopen_reg;
        done_next       = 1'b0;
        found_next      = 1'b0;
        step_valid_next = 1'b0;
        step_x_next     = '0;
        step_y_next     = '0;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        idx_next        = idx_reg;
        p1_idx_next     = p1_idx_reg;
        p2_idx_next     = p2_idx_reg;
        p2_cell_next    = p2_cell_reg;
        best_f_next     = best_f_reg;
        best_idx_next   = best_idx_reg;
        best_cell_next  = best_cell_reg;
        best_g_next     = best_g_reg;
        cur_next        = cur_reg;
        cur_g_next      = cur_g_reg;
        del_a_next      = del_a_reg;
        n_next          = n_reg;
        obst_we = 1'b0; obst_wa = '0; obst_wd = 1'b0; obst_ra = '0;
        resv_we = 1'b0; resv_wa = '0; resv_wd = 1'b0; resv_ra = '0;
        flag_we = 1'b0; flag_wa = '0; flag_wd = FLAG_NONE; flag_ra = '0;
        node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = '0;
        ord_we  = 1'b0; ord_wa  = '0; ord_wd  = '0; ord_ra  = '0;
        path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = '0;
        hreq.go = 1'b0;
        hreq.x  = sx_reg;
        hreq.y  = sy_reg;
        hreq.ex = ex_reg;
        hreq.ey = ey_reg;
        fin     = 1'b0;
        adv_dir = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                obst_we    = 1'b1;
                obst_wa    = sweep_reg;
                resv_we    = 1'b1;
                resv_wa    = sweep_reg;
                sweep_next = sweep_reg + CELL_W'(1);
                if (sweep_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    sx_next  = start_x;
                    sy_next  = start_y;
                    ex_next  = end_x;
                    ey_next  = end_y;
                    idx_next = step_index;
                    unique case (op_t'(op))
                        OP_OBST:
                        begin
                            obst_we = 1'b1;
                            obst_wa = {start_y, start_x};
                            obst_wd = blocked;
                            fin     = 1'b1;
                        end
                        OP_ROUTE:
                        begin
                            stored_len_next = '0;
                            if ({start_y, start_x} == {end_y, end_x})
                                fin = 1'b1;
                            else
                            begin
                                obst_ra    = {start_y, start_x};
                                state_next = S_CHK_S;
                            end
                        end
                        OP_READ:
                        begin
                            path_ra    = step_index;
                            state_next = S_RDP;
                        end
                        OP_UNRESV:
                            state_next = S_RCLR;
                    endcase
                end
            end
            S_CHK_S:
            begin
                if (obst_rd_reg)
                    fin = 1'b1;
                else
                begin
                    obst_ra    = {ey_reg, ex_reg};
                    state_next = S_CHK_E;
                end
            end
            S_CHK_E:
            begin
                if (obst_rd_reg)
                    fin = 1'b1;
                else
                    state_next = S_FCLR;
            end
            S_FCLR:
            begin
                flag_we    = 1'b1;
                flag_wa    = sweep_reg;
                sweep_next = sweep_reg + CELL_W'(1);
                if (sweep_reg == '1)
                    state_next = S_HS;
            end
            S_HS:
            begin
                hreq.go    = 1'b1;
                state_next = S_HSW;
            end
            S_HSW:
            begin
                if (hrsp.done)
                begin
                    node_we    = 1'b1;
                    node_wa    = {sy_reg, sx_reg};
                    node_wd    = '{g: '0, h: hrsp.h, d: DIR_XM};
                    flag_we    = 1'b1;
                    flag_wa    = {sy_reg, sx_reg};
                    flag_wd    = FLAG_OPEN;
                    ord_we     = 1'b1;
                    ord_wa     = '0;
                    ord_wd     = {sy_reg, sx_reg};
                    cnt_next   = CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg != cnt_reg)
                begin
                    ord_ra      = scan_reg[CELL_W-1:0];
                    p1_v_next   = 1'b1;
                    p1_idx_next = scan_reg[CELL_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                node_ra      = ord_rd_reg;
                p2_v_next    = p1_v_reg;
                p2_idx_next  = p1_idx_reg;
                p2_cell_next = ord_rd_reg;
                // Strict compare keeps the earliest inserted entry on a tie.
                if (p2_v_reg && (!best_v_reg || scan_f < best_f_reg))
                begin
                    best_v_next    = 1'b1;
                    best_f_next    = scan_f;
                    best_idx_next  = p2_idx_reg;
                    best_cell_next = p2_cell_reg;
                    best_g_next    = node_rd_reg.g;
                end
                if (scan_reg == cnt_reg && !p1_v_reg && !p2_v_reg)
                begin
                    cur_next    = best_cell_reg;
                    cur_g_next  = best_g_reg;
                    del_j_next  = CNT_W'(best_idx_reg) + CNT_W'(1);
                    scan_next   = '0;
                    best_v_next = 1'b0;
                    state_next  = S_DEL;
                end
            end
            S_DEL:
            begin
                if (del_j_reg < cnt_reg)
                begin
                    ord_ra     = del_j_reg[CELL_W-1:0];
                    del_v_next = 1'b1;
                    del_a_next = del_j_reg[CELL_W-1:0] - CELL_W'(1);
                    del_j_next = del_j_reg + CNT_W'(1);
                end
                if (del_v_reg)
                begin
                    ord_we = 1'b1;
                    ord_wa = del_a_reg;
                    ord_wd = ord_rd_reg;
                end
                if (del_j_reg >= cnt_reg && !del_v_reg)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    flag_we  = 1'b1;
                    flag_wa  = cur_reg;
                    flag_wd  = FLAG_CLOSED;
                    if (cur_reg == {ey_reg, ex_reg})
                    begin
                        stored_len_next = cur_g_reg;
                        bt_pos_next     = cur_g_reg - G_W'(1);
                        state_next      = S_BT;
                    end
                    else
                    begin
                        dir_next   = DIR_XM;
                        state_next = S_NB;
                    end
                end
            end
            S_NB:
            begin
                if (nb_ok)
                begin
                    n_next     = nb_cell;
                    obst_ra    = nb_cell;
                    resv_ra    = nb_cell;
                    flag_ra    = nb_cell;
                    node_ra    = nb_cell;
                    state_next = S_NCHK;
                end
                else
                    adv_dir = 1'b1;
            end
            S_NCHK:
            begin
                if (flag_rd_reg[CLOSED_BIT] || obst_rd_reg || resv_rd_reg)
                    adv_dir = 1'b1;
                else if (!flag_rd_reg[OPEN_BIT] || ng < node_rd_reg.g)
                begin
                    hreq.go    = 1'b1;
                    hreq.x     = n_reg[X_W-1:0];
                    hreq.y     = n_reg[CELL_W-1:X_W];
                    nopen_next = flag_rd_reg[OPEN_BIT];
                    state_next = S_NH;
                end
                else
                    adv_dir = 1'b1;
            end
            S_NH:
            begin
                if (hrsp.done)
                begin
                    node_we = 1'b1;
                    node_wa = n_reg;
                    node_wd = '{g: ng, h: hrsp.h, d: dir_reg};
                    if (!nopen_reg)
                    begin
                        flag_we  = 1'b1;
                        flag_wa  = n_reg;
                        flag_wd  = FLAG_OPEN;
                        ord_we   = 1'b1;
                        ord_wa   = cnt_reg[CELL_W-1:0];
                        ord_wd   = n_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    adv_dir = 1'b1;
                end
            end
            S_BT:
            begin
                node_ra    = cur_reg;
                state_next = S_BT2;
            end
            S_BT2:
            begin
                path_we = 1'b1;
                path_wa = bt_pos_reg;
                path_wd = cur_reg;
                resv_we = 1'b1;
                resv_wa = cur_reg;
                resv_wd = 1'b1;
                if (bt_pos_reg == '0 || !pa_ok)
                begin
                    fin        = 1'b1;
                    found_next = 1'b1;
                end
                else
                begin
                    cur_next    = pa_cell;
                    bt_pos_next = bt_pos_reg - G_W'(1);
                    state_next  = S_BT;
                end
            end
            S_RDP:
            begin
                fin = 1'b1;
                if (idx_reg < stored_len_reg)
                begin
                    step_valid_next = 1'b1;
                    step_x_next     = path_rd_reg[X_W-1:0];
                    step_y_next     = path_rd_reg[CELL_W-1:X_W];
                end
            end
            S_RCLR:
            begin
                resv_we    = 1'b1;
                resv_wa    = sweep_reg;
                sweep_next = sweep_reg + CELL_W'(1);
                if (sweep_reg == '1)
                    fin = 1'b1;
            end
        endcase

        if (adv_dir)
        begin
            if (dir_reg == DIR_XP)
            begin
                if (cnt_next == '0)
                    fin = 1'b1;
                else
                    state_next = S_SCAN;
            end
            else
            begin
                dir_next   = dir_t'(dir_reg + 2'd1);
                state_next = S_NB;
            end
        end

        if (fin)
        begin
            done_next  = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sweep_reg      <= '0;
            stored_len_reg <= '0;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            best_v_reg     <= 1'b0;
            del_j_reg      <= '0;
            del_v_reg      <= 1'b0;
            dir_reg        <= DIR_XM;
            bt_pos_reg     <= '0;
            nopen_reg      <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            stored_len_reg <= stored_len_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            p1_v_reg       <= p1_v_next;
            p2_v_reg       <= p2_v_next;
            best_v_reg     <= best_v_next;
            del_j_reg      <= del_j_next;
            del_v_reg      <= del_v_next;
            dir_reg        <= dir_next;
            bt_pos_reg     <= bt_pos_next;
            nopen_reg      <= nopen_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            step_valid_reg <= step_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        ex_reg        <= ex_next;
        ey_reg        <= ey_next;
        idx_reg       <= idx_next;
        p1_idx_reg    <= p1_idx_next;
        p2_idx_reg    <= p2_idx_next;
        p2_cell_reg   <= p2_cell_next;
        best_f_reg    <= best_f_next;
        best_idx_reg  <= best_idx_next;
        best_cell_reg <= best_cell_next;
        best_g_reg    <= best_g_next;
        cur_reg       <= cur_next;
        cur_g_reg     <= cur_g_next;
        del_a_reg     <= del_a_next;
        n_reg         <= n_next;
        step_x_reg    <= step_x_next;
        step_y_reg    <= step_y_next;
    end

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign found       = found_reg;
    assign path_length = stored_len_reg;
    assign step_valid  = step_valid_reg;
    assign step_x      = step_x_reg;
    assign step_y      = step_y_reg;

    `GAR_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
    `GAR_ASSERT_IMP(a_found_has_path, done && found, path_length != '0)
    `GAR_ASSERT_IMP(a_read_not_route, done && step_valid, !found)
    `GAR_ASSERT_IMP(a_scan_nonempty, state_reg == S_SCAN, cnt_reg != '0)

endmodule

/* sim/tb_grid_astar_router.sv */
`timescale 1ns / 1ps
module tb_grid_astar_router;
    import gar_pkg::*;

    localparam longint CYCLE_LIMIT = 200000000;
    localparam int     PEND_DEPTH  = 16;
    localparam int     ROW_MAX     = 32;
    localparam int     RAND_ITEMS  = 76;

    typedef struct packed {
        logic              found;
        logic [G_W-1:0]    len;
        logic              sv;
        logic [X_W-1:0]    sx;
        logic [Y_W-1:0]    sy;
    } answer_t;

    typedef struct {
        op_t               op;
        logic [X_W-1:0]    sx;
        logic [Y_W-1:0]    sy;
        logic [X_W-1:0]    ex;
        logic [Y_W-1:0]    ey;
        logic              blk;
        logic [CELL_W-1:0] idx;
        bit                typed;
        answer_t           ans;
    } word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        op = 2'd0;
    logic [X_W-1:0]    start_x = '0;
    logic [Y_W-1:0]    start_y = '0;
    logic [X_W-1:0]    end_x = '0;
    logic [Y_W-1:0]    end_y = '0;
    logic              blocked = 1'b0;
    logic [CELL_W-1:0] step_index = '0;
    logic              done;
    logic              found;
    logic [G_W-1:0]    path_length;
    logic              step_valid;
    logic [X_W-1:0]    step_x;
    logic [Y_W-1:0]    step_y;

    grid_astar_router u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .blocked(blocked), .step_index(step_index), .done(done), .found(found),
        .path_length(path_length), .step_valid(step_valid), .step_x(step_x),
        .step_y(step_y)
    );

    always #2 clk = ~clk;

    // Shadow copy of the router's maps and search state.
    bit  obst_map [NCELLS];
    bit  resv_map [NCELLS];
    bit  closed_map [NCELLS];
    bit  open_map [NCELLS];
    int  cost_g [NCELLS];
    int  est_h [NCELLS];
    int  back_dir [NCELLS];
    int  open_list [NCELLS];
    int  open_cnt;
    int  path_store [NCELLS];
    int  path_len;

    answer_t pend_mem [PEND_DEPTH];
    int      pend_wr = 0;
    int      pend_rd = 0;
    word_t   table_rows [ROW_MAX];
    int      row_cnt = 0;
    int      mismatches = 0;
    longint  cycles = 0;

    function automatic int euclid_h(int x, int y, int ex, int ey);
        longint dx, dy, v, r, t;
        dx = x > ex ? x - ex : ex - x;
        dy = y > ey ? y - ey : ey - y;
        v = (dx * dx + dy * dy) << (2 * FRAC);
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    function automatic bit search_path(int sx, int sy, int ex, int ey);
        int s, e, best, cur, cx, cy, nx, ny, n, ng, c, len;
        longint bf, f;
        int ddx[4] = '{-1, 0, 0, 1};
        int ddy[4] = '{0, -1, 1, 0};
        path_len = 0;
        s = sy * GRID_W + sx;
        e = ey * GRID_W + ex;
        if (s == e || obst_map[s] || obst_map[e])
            return 0;
        for (int i = 0; i < NCELLS; i++) begin
            closed_map[i] = 0;
            open_map[i] = 0;
        end
        cost_g[s] = 0;
        est_h[s] = euclid_h(sx, sy, ex, ey);
        back_dir[s] = 0;
        open_map[s] = 1;
        open_list[0] = s;
        open_cnt = 1;
        while (open_cnt > 0) begin
            best = 0;
            bf = (longint'(cost_g[open_list[0]]) << FRAC) + est_h[open_list[0]];
            for (int i = 1; i < open_cnt; i++) begin
                f = (longint'(cost_g[open_list[i]]) << FRAC) + est_h[open_list[i]];
                if (f < bf) begin
                    bf = f;
                    best = i;
                end
            end
            cur = open_list[best];
            for (int i = best; i + 1 < open_cnt; i++)
                open_list[i] = open_list[i + 1];
            open_cnt--;
            open_map[cur] = 0;
            closed_map[cur] = 1;
            if (cur == e) begin
                len = cost_g[e] > NCELLS ? NCELLS : cost_g[e];
                c = e;
                for (int k = 0; k < len; k++) begin
                    path_store[len - 1 - k] = c;
                    resv_map[c] = 1;
                    c = (c / GRID_W - ddy[back_dir[c]]) * GRID_W
                        + (c % GRID_W - ddx[back_dir[c]]);
                end
                path_len = len;
                return 1;
            end
            cx = cur % GRID_W;
            cy = cur / GRID_W;
            for (int d = 0; d < 4; d++) begin
                nx = cx + ddx[d];
                ny = cy + ddy[d];
                if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H)
                    continue;
                n = ny * GRID_W + nx;
                if (closed_map[n] || obst_map[n] || resv_map[n])
                    continue;
                ng = cost_g[cur] + 1;
                if (!open_map[n] || ng < cost_g[n]) begin
                    cost_g[n] = ng;
                    est_h[n] = euclid_h(nx, ny, ex, ey);
                    back_dir[n] = d;
                    if (!open_map[n]) begin
                        open_map[n] = 1;
                        open_list[open_cnt++] = n;
                    end
                end
            end
        end
        return 0;
    endfunction

    function automatic answer_t predict_router(word_t w);
        answer_t a;
        a = '{default: '0};
        case (w.op)
            OP_OBST: obst_map[w.sy * GRID_W + w.sx] = w.blk;
            OP_ROUTE: a.found = search_path(w.sx, w.sy, w.ex, w.ey);
            OP_READ:
                if (w.idx < path_len) begin
                    a.sv = 1;
                    a.sx = X_W'(path_store[w.idx] % GRID_W);
                    a.sy = Y_W'(path_store[w.idx] / GRID_W);
                end
            default:
                for (int i = 0; i < NCELLS; i++)
                    resv_map[i] = 0;
        endcase
        a.len = G_W'(path_len);
        return a;
    endfunction

    task automatic send_word(word_t w);
        answer_t a;
        op <= w.op;
        start_x <= w.sx;
        start_y <= w.sy;
        end_x <= w.ex;
        end_y <= w.ey;
        blocked <= w.blk;
        step_index <= w.idx;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        a = predict_router(w);
        if (w.typed && a != w.ans) begin
            if (mismatches < 10)
                $display("typed answer %h disagrees with prediction %h for op %0d",
                    w.ans, a, w.op);
            mismatches++;
        end
        pend_mem[pend_wr % PEND_DEPTH] = w.typed ? w.ans : a;
        pend_wr++;
    endtask

    task automatic pause_sender(int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    always @(posedge clk) begin
        answer_t exp_a;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && done) begin
            if (pend_wr == pend_rd) begin
                if (mismatches < 10)
                    $display("unexpected result word");
                mismatches++;
            end else begin
                exp_a = pend_mem[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (found !== exp_a.found || path_length !== exp_a.len
                    || step_valid !== exp_a.sv || step_x !== exp_a.sx
                    || step_y !== exp_a.sy) begin
                    if (mismatches < 10)
                        $display("exp f=%0d len=%0d v=%0d x=%0d y=%0d got %0d %0d %0d %0d %0d",
                            exp_a.found, exp_a.len, exp_a.sv, exp_a.sx, exp_a.sy,
                            found, path_length, step_valid, step_x, step_y);
                    mismatches++;
                end
            end
        end
    end

    function automatic word_t mk(op_t o, int sx, int sy, int ex, int ey, int blk, int idx);
        word_t w;
        w.op = o;
        w.sx = X_W'(sx);
        w.sy = Y_W'(sy);
        w.ex = X_W'(ex);
        w.ey = Y_W'(ey);
        w.blk = 1'(blk);
        w.idx = CELL_W'(idx);
        w.typed = 0;
        w.ans = '{default: '0};
        return w;
    endfunction

    function automatic word_t mk_typed(word_t w, int f, int len, int sv);
        w.typed = 1;
        w.ans.found = 1'(f);
        w.ans.len = G_W'(len);
        w.ans.sv = 1'(sv);
        return w;
    endfunction

    function automatic void add_row(word_t w);
        table_rows[row_cnt] = w;
        row_cnt++;
    endfunction

    initial begin
        word_t w;
        int pct, bx, by, ex, ey, tries;
        for (int i = 0; i < NCELLS; i++) begin
            obst_map[i] = 0;
            resv_map[i] = 0;
        end
        path_len = 0;
        open_cnt = 0;

        // Directed sequence: reset state, edges of the grid, and corner cases.
        add_row(mk_typed(mk(OP_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0));
        add_row(mk_typed(mk(OP_ROUTE, 5, 5, 5, 5, 0, 0), 0, 0, 0));
        add_row(mk_typed(mk(OP_OBST, 63, 31, 0, 0, 1, 2047), 0, 0, 0));
        add_row(mk_typed(mk(OP_ROUTE, 0, 31, 63, 31, 0, 0), 0, 0, 0));
        add_row(mk_typed(mk(OP_OBST, 63, 31, 0, 0, 0, 0), 0, 0, 0));
        add_row(mk(OP_ROUTE, 0, 0, 63, 0, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 62));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 2047));
        add_row(mk(OP_ROUTE, 63, 31, 60, 31, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 2));
        add_row(mk(OP_UNRESV, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_OBST, 1, 0, 0, 0, 1, 0));
        add_row(mk(OP_OBST, 0, 1, 0, 0, 1, 0));
        add_row(mk(OP_ROUTE, 0, 0, 5, 0, 0, 0));
        add_row(mk(OP_ROUTE, 2, 0, 4, 0, 0, 0));
        add_row(mk(OP_ROUTE, 3, 0, 3, 2, 0, 0));
        add_row(mk(OP_ROUTE, 0, 0, 3, 1, 0, 0));
        add_row(mk(OP_ROUTE, 1, 0, 5, 5, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_UNRESV, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_OBST, 1, 0, 0, 0, 0, 0));
        add_row(mk(OP_OBST, 0, 1, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < row_cnt; i++)
            send_word(table_rows[i]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            pct = n < 25 ? 14 : (n < 50 ? 83 : 0);
            if (n == 38) begin
                start <= 1'b0;
                while (pend_wr != pend_rd)
                    @(posedge clk);
                @(posedge clk);
            end
            pause_sender(pct);
            bx = $urandom_range(0, GRID_W - 1);
            by = $urandom_range(0, GRID_H - 1);
            w = mk(OP_READ, bx, by, $urandom_range(0, GRID_W - 1),
                $urandom_range(0, GRID_H - 1), $urandom_range(0, 1),
                $urandom_range(0, NCELLS - 1));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    w.op = OP_OBST;
                7, 8, 9, 10, 11, 12, 13: begin
                    w.op = OP_ROUTE;
                    tries = 0;
                    do begin
                        ex = bx + $urandom_range(0, 12) - 6;
                        ey = by + $urandom_range(0, 12) - 6;
                        ex = ex < 0 ? 0 : (ex >= GRID_W ? GRID_W - 1 : ex);
                        ey = ey < 0 ? 0 : (ey >= GRID_H ? GRID_H - 1 : ey);
                        tries++;
                    end while (tries < 30 && (resv_map[ey * GRID_W + ex]
                        || obst_map[ey * GRID_W + ex]
                        || (ex == bx && ey == by)));
                    w.ex = X_W'(ex);
                    w.ey = Y_W'(ey);
                    if ($urandom_range(0, 9) == 0) begin
                        w.ex = X_W'(bx);
                        w.ey = Y_W'(by);
                    end
                end
                14, 15, 16, 17:
                    if ($urandom_range(0, 3) != 0)
                        w.idx = CELL_W'($urandom_range(0, path_len + 1));
                default:
                    w.op = OP_UNRESV;
            endcase
            send_word(w);
        end
        start <= 1'b0;

        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pend_wr == pend_rd)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
